### design/mgdt_pkg.sv
// ----------------------------------------------------------------------------
// MAC group device table package
// Shared sizes, command and status codes, transaction types and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mgdt_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 64;
  localparam int MAX_RESULTS   = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int EMIT_W        = $clog2(MAX_RESULTS + 1);

  // Field widths.
  localparam int MAC_W   = 48;
  localparam int GRP_W   = 16;
  localparam int COUNT_W = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  // Command codes.
  typedef enum logic [2:0] {
    CMD_ADD        = 3'd0,
    CMD_UPDATE     = 3'd1,
    CMD_REMOVE     = 3'd2,
    CMD_CLEAR      = 3'd3,
    CMD_COUNT_GRP  = 3'd4,
    CMD_COUNT_GRPS = 3'd5,
    CMD_LIST_GRP   = 3'd6
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_PRESENT   = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_IREAD,
    S_ICHECK,
    S_CLEAR,
    S_RESULT
  } state_e;

  // Input transaction.
  typedef struct packed {
    logic [2:0]       cmd;
    logic [MAC_W-1:0] mac;
    logic [GRP_W-1:0] dev_grp;
  } dev_cmd_t;

  // Result transaction.
  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
    logic [MAC_W-1:0]   mac_out;
    logic [GRP_W-1:0]   group_out;
    logic               last;
  } dev_res_t;

  // One stored table entry, with its valid bit.
  typedef struct packed {
    logic             vld;
    logic [MAC_W-1:0] mac;
    logic [GRP_W-1:0] grp;
  } entry_t;

  // Saturate an internal count to the result field.
  function automatic logic [COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] n);
    if (32'(n) > 32'(COUNT_MAX)) begin
      return COUNT_MAX;
    end else begin
      return COUNT_W'(n);
    end
  endfunction

endpackage

### design/mac_group_device_table.sv
// ----------------------------------------------------------------------------
// MAC group device table
// Table of MAC keyed device entries with a group id each, driven by a small
// sequencer that scans the entries one slot at a time through a single
// compare unit. The valid bit of each slot is kept in the entry memory.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  -------  ---------  ---------------------  ---------------------------------
//  in       input      in_valid_i/in_ready_o   dev_cmd_t: cmd, mac, dev_grp
//  out      output     out_valid_o/out_ready_i dev_res_t: status, count,
//                                              mac_out, group_out, last
//
//  Every slot visit is an entry read, then a compare. Clear writes each
//  slot once; count scans the whole table; add scans it unless the MAC is
//  found; update and remove stop at the matching entry; list makes a
//  counting pass and, for a non-empty group, a second pass that stops at
//  the last member. Counting distinct groups compares each valid entry
//  with all lower slots through the same port. Reset starts a clearing
//  pass over all N = TABLE_ENTRIES slots; the block is not ready meanwhile.
//  A result waits in the output register; a stalled output holds the
//  sequencer only when it has a new result to load.
//
`timescale 1ns / 1ps

module mac_group_device_table import mgdt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dev_cmd_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dev_res_t out_data_o
);

  // Sequencer and command registers.
  state_e             state_q, state_d;
  logic [2:0]         cmd_q;
  logic [MAC_W-1:0]   mac_q;
  logic [GRP_W-1:0]   grp_q, grp_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   jdx_q, jdx_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   total_q, total_d;
  logic [EMIT_W-1:0]  emit_q, emit_d;
  logic               phase_q, phase_d;
  logic               free_vld_q, free_vld_d;
  logic [IDX_W-1:0]   free_idx_q, free_idx_d;
  logic [1:0]         status_q, status_d;

  // Storage.
  entry_t                   mem_q [TABLE_ENTRIES];
  entry_t                   rd_data_q;

  // Output register.
  logic     out_valid_q;
  dev_res_t out_q;

  // Combinational controls.
  logic             in_accept;
  logic             out_free;
  logic             out_load;
  dev_res_t         out_d;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             cur_valid;
  logic             hit_mac;
  logic             hit_grp;
  logic             last_idx;
  logic [CNT_W-1:0] cnt_nx;
  logic [31:0]      emit_lim;
  logic             last_emit;
  logic             inner_valid;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Compare unit on the entry just read.
  assign cur_valid   = rd_data_q.vld;
  assign inner_valid = rd_data_q.vld;
  assign hit_mac     = cur_valid && (rd_data_q.mac == mac_q);
  assign hit_grp     = cur_valid && (rd_data_q.grp == grp_q);
  assign last_idx    = (idx_q == IDX_W'(TABLE_ENTRIES - 1));
  assign cnt_nx      = hit_grp ? (cnt_q + CNT_W'(1)) : cnt_q;
  assign emit_lim    = (32'(total_q) > 32'(MAX_RESULTS)) ? 32'(MAX_RESULTS)
                                                         : 32'(total_q);
  assign last_emit   = ((32'(emit_q) + 32'd1) == emit_lim);

  // State register and command capture.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      idx_q       <= '0;
      jdx_q       <= '0;
      cnt_q       <= '0;
      total_q     <= '0;
      emit_q      <= '0;
      phase_q     <= 1'b0;
      free_vld_q  <= 1'b0;
      free_idx_q  <= '0;
      status_q    <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      jdx_q      <= jdx_d;
      cnt_q      <= cnt_d;
      total_q    <= total_d;
      emit_q     <= emit_d;
      phase_q    <= phase_d;
      free_vld_q <= free_vld_d;
      free_idx_q <= free_idx_d;
      status_q   <= status_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= in_data_i.cmd;
      mac_q <= in_data_i.mac;
    end
    grp_q <= grp_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  // Next state and controls.
  always_comb begin
    state_d    = state_q;
    grp_d      = grp_q;
    idx_d      = idx_q;
    jdx_d      = jdx_q;
    cnt_d      = cnt_q;
    total_d    = total_q;
    emit_d     = emit_q;
    phase_d    = phase_q;
    free_vld_d = free_vld_q;
    free_idx_d = free_idx_q;
    status_d   = status_q;
    out_load   = 1'b0;
    out_d      = out_q;
    mem_re     = 1'b0;
    mem_raddr  = idx_q;
    mem_we     = 1'b0;
    mem_waddr  = idx_q;
    mem_wdata  = rd_data_q;

    case (state_q)
      // Clearing pass: one slot is written invalid per cycle.
      S_INIT, S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = '0;
        idx_d     = idx_q + IDX_W'(1);
        if (last_idx) begin
          state_d = (state_q == S_INIT) ? S_IDLE : S_RESULT;
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          grp_d      = in_data_i.dev_grp;
          idx_d      = '0;
          jdx_d      = '0;
          cnt_d      = '0;
          emit_d     = '0;
          phase_d    = 1'b0;
          free_vld_d = 1'b0;
          status_d   = STAT_OK;
          case (in_data_i.cmd)
            CMD_CLEAR: begin
              state_d = S_CLEAR;
            end
            CMD_ADD, CMD_UPDATE, CMD_REMOVE, CMD_COUNT_GRP, CMD_COUNT_GRPS,
            CMD_LIST_GRP: begin
              state_d = S_READ;
            end
            default: begin
              state_d = S_RESULT;
            end
          endcase
        end
      end

      // Fetch the entry at the outer index.
      S_READ: begin
        mem_re    = 1'b1;
        mem_raddr = idx_q;
        state_d   = S_CHECK;
      end

      S_CHECK: begin
        case (cmd_q)
          CMD_ADD: begin
            if (hit_mac) begin
              status_d = STAT_PRESENT;
              state_d  = S_RESULT;
            end else begin
              if (!cur_valid && !free_vld_q) begin
                free_vld_d = 1'b1;
                free_idx_d = idx_q;
              end
              if (last_idx) begin
                // Whole table seen: insert into the lowest free slot.
                if (free_vld_q || !cur_valid) begin
                  mem_we    = 1'b1;
                  mem_waddr = free_vld_q ? free_idx_q : idx_q;
                  mem_wdata = '{vld: 1'b1, mac: mac_q, grp: grp_q};
                  status_d  = STAT_OK;
                end else begin
                  status_d = STAT_FULL;
                end
                state_d = S_RESULT;
              end else begin
                idx_d   = idx_q + IDX_W'(1);
                state_d = S_READ;
              end
            end
          end

          CMD_UPDATE, CMD_REMOVE: begin
            if (hit_mac) begin
              mem_we    = 1'b1;
              mem_waddr = idx_q;
              if (cmd_q == CMD_UPDATE) begin
                mem_wdata = '{vld: 1'b1, mac: rd_data_q.mac, grp: grp_q};
              end else begin
                mem_wdata = '{vld: 1'b0, mac: rd_data_q.mac, grp: rd_data_q.grp};
              end
              status_d = STAT_OK;
              state_d  = S_RESULT;
            end else if (last_idx) begin
              status_d = STAT_NOT_FOUND;
              state_d  = S_RESULT;
            end else begin
              idx_d   = idx_q + IDX_W'(1);
              state_d = S_READ;
            end
          end

          CMD_COUNT_GRP: begin
            cnt_d = cnt_nx;
            if (last_idx) begin
              state_d = S_RESULT;
            end else begin
              idx_d   = idx_q + IDX_W'(1);
              state_d = S_READ;
            end
          end

          CMD_COUNT_GRPS: begin
            if (cur_valid && (idx_q != '0)) begin
              // Look for the same group in a lower slot.
              grp_d   = rd_data_q.grp;
              jdx_d   = '0;
              state_d = S_IREAD;
            end else begin
              if (cur_valid) begin
                cnt_d = cnt_q + CNT_W'(1);
              end
              if (last_idx) begin
                state_d = S_RESULT;
              end else begin
                idx_d   = idx_q + IDX_W'(1);
                state_d = S_READ;
              end
            end
          end

          CMD_LIST_GRP: begin
            if (!phase_q) begin
              // First pass counts the members.
              cnt_d = cnt_nx;
              if (last_idx) begin
                if (cnt_nx == '0) begin
                  state_d = S_RESULT;
                end else begin
                  total_d = cnt_nx;
                  phase_d = 1'b1;
                  emit_d  = '0;
                  idx_d   = '0;
                  state_d = S_READ;
                end
              end else begin
                idx_d   = idx_q + IDX_W'(1);
                state_d = S_READ;
              end
            end else if (hit_grp) begin
              // Second pass gives one result per member; waits on the output.
              if (out_free) begin
                out_load = 1'b1;
                out_d    = '{status:    STAT_OK,
                             count:     sat_count(total_q),
                             mac_out:   rd_data_q.mac,
                             group_out: rd_data_q.grp,
                             last:      last_emit};
                emit_d   = emit_q + EMIT_W'(1);
                if (last_emit || last_idx) begin
                  state_d = S_IDLE;
                end else begin
                  idx_d   = idx_q + IDX_W'(1);
                  state_d = S_READ;
                end
              end
            end else if (last_idx) begin
              state_d = S_IDLE;
            end else begin
              idx_d   = idx_q + IDX_W'(1);
              state_d = S_READ;
            end
          end

          default: begin
            state_d = S_RESULT;
          end
        endcase
      end

      // Fetch the entry at the inner index.
      S_IREAD: begin
        mem_re    = 1'b1;
        mem_raddr = jdx_q;
        state_d   = S_ICHECK;
      end

      S_ICHECK: begin
        if (inner_valid && (rd_data_q.grp == grp_q)) begin
          // Group seen before; move on to the next outer slot.
          if (last_idx) begin
            state_d = S_RESULT;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_READ;
          end
        end else if (jdx_q == (idx_q - IDX_W'(1))) begin
          // No lower slot holds this group: it is a new one.
          cnt_d = cnt_q + CNT_W'(1);
          if (last_idx) begin
            state_d = S_RESULT;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_READ;
          end
        end else begin
          jdx_d   = jdx_q + IDX_W'(1);
          state_d = S_IREAD;
        end
      end

      // Single result transaction for the command.
      S_RESULT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '{status:    status_q,
                       count:     sat_count(cnt_q),
                       mac_out:   '0,
                       group_out: '0,
                       last:      1'b1};
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // After a command is accepted, the block is not ready in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("block ready right after accepting a command");

  // The running count never exceeds the table size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(TABLE_ENTRIES))
    else $error("count beyond table size");

  // The inner scan stays below the outer slot.
  a_inner_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ICHECK || state_q == S_IREAD) |-> (jdx_q < idx_q))
    else $error("inner index reached outer index");

  // Error results are single, final and carry no count.
  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status != STAT_OK)) |->
      (out_q.last && (out_q.count == '0)))
    else $error("error result not final or with a count");
`endif

endmodule
